FILE: sv/pidc_pkg.sv
// Package for the clamped PID controller: word types, constants and codes.
// No dependencies; used by the top level alone, by scoped names.
`default_nettype none
package pidc_pkg;

    localparam int unsigned TickRate = 1000000;
    localparam int unsigned FracBits = 16;

    // register indexes
    localparam logic [2:0] REG_PROP   = 3'd0;
    localparam logic [2:0] REG_INTEG  = 3'd1;
    localparam logic [2:0] REG_DERIV  = 3'd2;
    localparam logic [2:0] REG_UPPER  = 3'd3;
    localparam logic [2:0] REG_LOWER  = 3'd4;
    localparam logic [2:0] REG_OFFSET = 3'd5;

    // actions
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    typedef struct packed {
        logic               action;
        logic signed [31:0] setpoint;
        logic signed [31:0] measured;
        logic        [31:0] stamp;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               limited;
    } t_out_word;

    // saturate a 66-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        begin
            hi = 66'sh0_7FFF_FFFF;
            lo = -66'sh0_8000_0000;
            if (v > hi) begin
                sat32 = 32'sh7FFF_FFFF;
            end else if (v < lo) begin
                sat32 = 32'sh8000_0000;
            end else begin
                sat32 = v[31:0];
            end
        end
    endfunction

endpackage
`default_nettype wire

FILE: sv/pidc_mul.sv
// Radix-2 serial multiplier: signed 34 x signed 33, one bit of b per cycle.
// Standalone; takes nothing from pidc_pkg.
`default_nettype none
module pidc_mul (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [33:0] i_a,
    input  wire logic signed [32:0] i_b,
    output logic                    o_done,
    output logic signed [65:0]      o_prod
);
    logic signed [65:0] r_acc, n_acc;
    logic        [32:0] r_b, n_b;
    logic signed [65:0] r_a, n_a;
    logic        [5:0]  r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;

    // add shifted multiplicand for each set bit, low bit first; the sign bit of b
    // carries negative weight, so subtract on the last step
    always_comb begin
        n_acc = r_acc; n_b = r_b; n_a = r_a; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        if (i_start) begin
            n_acc = '0; n_b = i_b; n_a = 66'(i_a); n_cnt = '0; n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_b[0]) begin
                if (r_cnt == 6'd32) n_acc = r_acc - r_a;
                else n_acc = r_acc + r_a;
            end
            n_a = r_a <<< 1;
            n_b = r_b >> 1;
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd32) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc; r_b <= n_b; r_a <= n_a; r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule
`default_nettype wire

FILE: sv/pidc_div.sv
// Restoring serial divider: signed 66-bit dividend by unsigned 32-bit divisor,
// quotient truncated toward zero, one quotient bit per cycle. Standalone.
`default_nettype none
module pidc_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [65:0] i_num,
    input  wire logic        [31:0] i_den,
    output logic                    o_done,
    output logic signed [65:0]      o_quo
);
    logic [65:0] r_q, n_q;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic        r_neg, n_neg;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] trial;
    logic [32:0] shifted;

    // shift in one dividend bit, subtract when it fits
    always_comb begin
        n_q = r_q; n_rem = r_rem; n_den = r_den; n_neg = r_neg; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        shifted = {r_rem[31:0], r_q[65]};
        trial = shifted - {1'b0, r_den};
        if (i_start) begin
            n_neg = i_num[65];
            n_q = i_num[65] ? 66'(-i_num) : i_num;
            n_rem = '0; n_den = i_den; n_cnt = '0; n_busy = 1'b1;
        end else if (r_busy) begin
            if (!trial[32]) begin
                n_rem = trial; n_q = {r_q[64:0], 1'b1};
            end else begin
                n_rem = shifted; n_q = {r_q[64:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd65) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q; r_rem <= n_rem; r_den <= n_den; r_neg <= n_neg; r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule
`default_nettype wire

FILE: sv/pid_controller_clamped.sv
// Clamped PID controller top level: sequencer over one serial multiplier and
// one serial divider. A sample word runs five multiplies and four divides;
// a clear word runs three multiplies. Each ends with one output step.
// One word at a time; the next is taken the cycle after the result is taken.
// Synchronous active-low reset clears the sequencer, error, integral,
// derivative and stamp registers and loads the register defaults.
`default_nettype none
module pid_controller_clamped (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire pidc_pkg::t_in_word  i_data,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output pidc_pkg::t_out_word      o_data,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_idx,
    input  wire logic [31:0]         i_cfg_data
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INCM = 4'd1;
    localparam logic [3:0] S_INCD = 4'd2;
    localparam logic [3:0] S_LOD  = 4'd3;
    localparam logic [3:0] S_HID  = 4'd4;
    localparam logic [3:0] S_DRD  = 4'd5;
    localparam logic [3:0] S_PM   = 4'd6;
    localparam logic [3:0] S_IM   = 4'd7;
    localparam logic [3:0] S_DM   = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;
    localparam logic [3:0] S_DRM  = 4'd10;

    logic signed [31:0] r_kp, r_kd, r_up, r_lo, r_off;
    logic        [30:0] r_ki;
    logic signed [31:0] r_last_err, r_err, r_integ, r_deriv, r_lo_lim;
    logic        [31:0] r_last_stamp, r_ticks;
    logic signed [65:0] r_sum;
    logic [3:0]  r_state, n_state;
    logic        r_ovalid;
    pidc_pkg::t_out_word r_out;

    logic               mul_start, div_start, mul_done, div_done;
    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p, div_num, div_q;
    logic        [31:0] div_den;
    logic signed [65:0] diff;
    logic signed [65:0] inc;
    logic signed [65:0] u_fin;
    logic signed [31:0] err_c;

    pidc_mul u_mul (.i_clk, .i_rst_n, .i_start(mul_start), .i_a(mul_a), .i_b(mul_b),
                    .o_done(mul_done), .o_prod(mul_p));
    pidc_div u_div (.i_clk, .i_rst_n, .i_start(div_start), .i_num(div_num),
                    .i_den(div_den), .o_done(div_done), .o_quo(div_q));

    assign err_c = pidc_pkg::sat32(66'(i_data.setpoint) - 66'(i_data.measured));
    assign diff  = 66'(r_err) - 66'(r_last_err);
    assign inc   = (div_q > 66'sh2_0000_0000) ? 66'sh2_0000_0000 :
                   (div_q < -66'sh2_0000_0000) ? -66'sh2_0000_0000 : div_q;
    assign u_fin = r_sum + (mul_p >>> pidc_pkg::FracBits);
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // choose operands for the shared units per step
    always_comb begin
        mul_start = 1'b0; div_start = 1'b0; n_state = r_state;
        mul_a = 34'(r_err); mul_b = {1'b0, r_ticks};
        div_num = 66'(r_lo) <<< pidc_pkg::FracBits; div_den = 32'(r_ki);
        unique case (r_state)
            S_IDLE: if (i_valid && o_ready) begin
                if (i_data.action == pidc_pkg::ACT_CLEAR) begin
                    n_state = S_PM; mul_start = 1'b1;
                    mul_a = 34'(r_err); mul_b = 33'(r_kp);
                end else begin
                    n_state = S_INCM; mul_start = 1'b1;
                    mul_a = 34'(err_c); mul_b = {1'b0, i_data.stamp - r_last_stamp};
                end
            end
            S_INCM: if (mul_done) begin
                n_state = S_INCD; div_start = 1'b1;
                div_num = mul_p; div_den = 32'(pidc_pkg::TickRate);
            end
            S_INCD: if (div_done) begin
                n_state = S_LOD; div_start = 1'b1;
                div_num = 66'(r_lo) <<< pidc_pkg::FracBits;
            end
            S_LOD: if (div_done) begin
                n_state = S_HID; div_start = 1'b1;
                div_num = 66'(r_up) <<< pidc_pkg::FracBits;
            end
            // scale the error change by the tick rate on the multiplier
            S_HID: if (div_done) begin
                n_state = S_DRM; mul_start = 1'b1;
                mul_a = 34'(diff); mul_b = 33'(pidc_pkg::TickRate);
            end
            S_DRM: if (mul_done) begin
                n_state = S_DRD; div_start = 1'b1;
                div_num = mul_p; div_den = r_ticks;
            end
            S_DRD: if (div_done) begin
                n_state = S_PM; mul_start = 1'b1;
                mul_a = 34'(r_err); mul_b = 33'(r_kp);
            end
            S_PM: if (mul_done) begin
                n_state = S_IM; mul_start = 1'b1;
                mul_a = 34'(r_integ); mul_b = {2'b00, r_ki};
            end
            S_IM: if (mul_done) begin
                n_state = S_DM; mul_start = 1'b1;
                mul_a = 34'(r_deriv); mul_b = 33'(r_kd);
            end
            S_DM: if (mul_done) n_state = S_OUT;
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ovalid <= 1'b0;
            r_kp <= 32'sd65536; r_ki <= '0; r_kd <= '0; r_up <= '0; r_lo <= '0; r_off <= '0;
            r_last_err <= '0; r_err <= '0; r_integ <= '0; r_deriv <= '0; r_last_stamp <= '0;
        end else begin
            r_state <= n_state;
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pidc_pkg::REG_PROP:   r_kp  <= i_cfg_data;
                    pidc_pkg::REG_INTEG:  r_ki  <= i_cfg_data[30:0];
                    pidc_pkg::REG_DERIV:  r_kd  <= i_cfg_data;
                    pidc_pkg::REG_UPPER:  r_up  <= i_cfg_data;
                    pidc_pkg::REG_LOWER:  r_lo  <= i_cfg_data;
                    pidc_pkg::REG_OFFSET: r_off <= i_cfg_data;
                    default: ;
                endcase
            end
            // drop the result once taken
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    if (i_data.action == pidc_pkg::ACT_CLEAR) begin
                        r_integ <= '0;
                    end else begin
                        r_ticks <= i_data.stamp - r_last_stamp;
                        r_last_stamp <= i_data.stamp;
                        r_last_err <= r_err;
                        r_err <= err_c;
                    end
                end
                S_INCD: if (div_done && r_ticks != '0)
                    r_integ <= pidc_pkg::sat32(66'(r_integ) + inc);
                S_LOD: if (div_done) r_lo_lim <= pidc_pkg::sat32(div_q);
                S_HID: if (div_done && r_ki != '0) begin
                    if (r_integ < r_lo_lim) r_integ <= r_lo_lim;
                    else if (r_integ > pidc_pkg::sat32(div_q))
                        r_integ <= pidc_pkg::sat32(div_q);
                end
                S_DRD: if (div_done) begin
                    if (r_ticks != '0) r_deriv <= pidc_pkg::sat32(div_q);
                    else if (diff > 0) r_deriv <= 32'sh7FFF_FFFF;
                    else if (diff < 0) r_deriv <= 32'sh8000_0000;
                    else r_deriv <= '0;
                end
                S_PM: if (mul_done) r_sum <= 66'(r_off) + (mul_p >>> pidc_pkg::FracBits);
                S_IM: if (mul_done) r_sum <= u_fin;
                S_DM: if (mul_done) r_sum <= u_fin;
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    if (r_sum > 66'(r_up)) begin
                        r_out.drive <= r_up; r_out.limited <= 1'b1;
                    end else if (r_sum < 66'(r_lo)) begin
                        r_out.drive <= r_lo; r_out.limited <= 1'b1;
                    end else begin
                        r_out.drive <= r_sum[31:0]; r_out.limited <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
